FILE: sv/lpc_pkg.sv
// shared constants and command codes of the log position converter
package lpc_pkg;

	localparam int PAGE_BYTES         = 8192;
	localparam int LONG_HEADER_BYTES  = 40;
	localparam int SHORT_HEADER_BYTES = 24;

	localparam int PAGE_LOG2     = $clog2(PAGE_BYTES);
	localparam int PAGE_PAYLOAD  = PAGE_BYTES - SHORT_HEADER_BYTES;
	localparam int FIRST_PAYLOAD = PAGE_BYTES - LONG_HEADER_BYTES;

	localparam int SEG_LOG2_MIN   = 20;
	localparam int SEG_LOG2_MAX   = 30;
	localparam int SEG_LOG2_RESET = 24;
	localparam int CFG_W          = 5;

	// width of the segment payload size and of any remainder below it
	localparam int USABLE_W = SEG_LOG2_MAX + 1;
	localparam int PP_W     = $clog2(PAGE_PAYLOAD + 1);
	localparam int PAGES_W  = SEG_LOG2_MAX - PAGE_LOG2;

	// rounded-up reciprocal of the page payload, exact for dividends below 2^USABLE_W
	localparam int RECIP_SHIFT = USABLE_W + PP_W;
	localparam longint unsigned PAGE_RECIP =
		((64'd1 << RECIP_SHIFT) + 64'(PAGE_PAYLOAD) - 64'd1) / 64'(PAGE_PAYLOAD);
	localparam int RECIP_W = $clog2(PAGE_RECIP + 64'd1);

	localparam int DATA_W     = 64;
	localparam int CMD_W      = 2;
	localparam int IN_TDATA_W = ((CMD_W + DATA_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((DATA_W + 1 + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_POS_TO_ADDR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POS_TO_END  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ADDR_TO_POS = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;

endpackage

FILE: sv/log_position_converter.sv
// Log position converter: turns a usable byte position into a physical log address (next byte
// or end form) or an address back into a position. One item is taken every cycle unless the
// master side stalls; its result passes 64 stages of the segment divider, two stages of the
// reciprocal page divide, a multiply stage and the output register. A stall on the master
// side holds the whole pipeline. A configuration write recomputes the segment payload size.
module log_position_converter
	import lpc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_W-1:0]       cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // cmd, operand, zero padding
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // converted, inside_header, zero padding
);

	localparam int SIDE1_W = CMD_W + DATA_W;
	localparam int SIDE2_W = CMD_W + DATA_W + DATA_W + USABLE_W;
	localparam int PG_PROD_W = USABLE_W + RECIP_W;

	logic [CFG_W-1:0]    lg_q;
	logic [USABLE_W-1:0] usable_q;
	logic [CFG_W-1:0]    lg_clamp;
	logic                adv;

	assign cfg_ready = 1'b1;
	assign adv       = !m_tvalid || m_tready;
	assign s_tready  = adv;

	always_comb begin
		if (cfg_data < CFG_W'(SEG_LOG2_MIN)) begin
			lg_clamp = CFG_W'(SEG_LOG2_MIN);
		end else if (cfg_data > CFG_W'(SEG_LOG2_MAX)) begin
			lg_clamp = CFG_W'(SEG_LOG2_MAX);
		end else begin
			lg_clamp = cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q     <= CFG_W'(SEG_LOG2_RESET);
			usable_q <= USABLE_W'((PAGE_PAYLOAD << (SEG_LOG2_RESET - PAGE_LOG2))
				+ SHORT_HEADER_BYTES - LONG_HEADER_BYTES);
		end else if (cfg_valid) begin
			lg_q     <= lg_clamp;
			usable_q <= (USABLE_W'(PAGE_PAYLOAD) << (lg_clamp - CFG_W'(PAGE_LOG2)))
				+ USABLE_W'(SHORT_HEADER_BYTES) - USABLE_W'(LONG_HEADER_BYTES);
		end
	end

	// segment divide: position by segment payload
	logic                d1_valid;
	logic [DATA_W-1:0]   d1_q;
	logic [USABLE_W-1:0] d1_r;
	logic [SIDE1_W-1:0]  d1_side;

	lpc_div #(.W(DATA_W), .DW(USABLE_W), .SW(SIDE1_W)) u_div_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (s_tvalid),
		.dividend  (s_tdata[CMD_W +: DATA_W]),
		.divisor   (usable_q),
		.in_side   (s_tdata[SIDE1_W-1:0]),
		.out_valid (d1_valid),
		.quotient  (d1_q),
		.remainder (d1_r),
		.out_side  (d1_side)
	);

	// page divide: remainder past the first page by page payload, via the reciprocal
	logic [USABLE_W-1:0]  d2_in;
	logic                 pg_vld_s1;
	logic [PG_PROD_W-1:0] pg_prod_s1;
	logic [USABLE_W-1:0]  pg_num_s1;
	logic [SIDE2_W-1:0]   pg_side_s1;
	logic [PAGES_W-1:0]   pg_quot;
	logic [USABLE_W-1:0]  pg_rem;
	logic                 pg_vld_s2;
	logic [PAGES_W-1:0]   pg_q_s2;
	logic [PP_W-1:0]      pg_r_s2;
	logic [SIDE2_W-1:0]   pg_side_s2;

	assign d2_in = (d1_r >= USABLE_W'(FIRST_PAYLOAD)) ? d1_r - USABLE_W'(FIRST_PAYLOAD) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pg_vld_s1 <= 1'b0;
			pg_vld_s2 <= 1'b0;
		end else if (adv) begin
			pg_vld_s1 <= d1_valid;
			pg_vld_s2 <= pg_vld_s1;
		end
	end

	assign pg_quot = pg_prod_s1[RECIP_SHIFT +: PAGES_W];
	assign pg_rem  = pg_num_s1 - USABLE_W'(pg_quot) * USABLE_W'(PAGE_PAYLOAD);

	always_ff @(posedge clk) begin
		if (adv) begin
			pg_prod_s1 <= PG_PROD_W'(d2_in) * PG_PROD_W'(PAGE_RECIP);
			pg_num_s1  <= d2_in;
			pg_side_s1 <= {d1_r, d1_q, d1_side};
			pg_q_s2    <= pg_quot;
			pg_r_s2    <= pg_rem[PP_W-1:0];
			pg_side_s2 <= pg_side_s1;
		end
	end

	logic                d2_valid;
	logic [PAGES_W-1:0]  d2_q;
	logic [PP_W-1:0]     d2_r;
	logic [SIDE2_W-1:0]  d2_side;

	assign d2_valid = pg_vld_s2;
	assign d2_q     = pg_q_s2;
	assign d2_r     = pg_r_s2;
	assign d2_side  = pg_side_s2;

	logic [CMD_W-1:0]    d2_cmd;
	logic [DATA_W-1:0]   d2_operand;
	logic [DATA_W-1:0]   d2_segq;
	logic [USABLE_W-1:0] d2_segr;

	assign d2_cmd     = d2_side[CMD_W-1:0];
	assign d2_operand = d2_side[CMD_W +: DATA_W];
	assign d2_segq    = d2_side[CMD_W + DATA_W +: DATA_W];
	assign d2_segr    = d2_side[CMD_W + 2 * DATA_W +: USABLE_W];

	// address decomposition for the reverse path
	logic [DATA_W-1:0]    segs;
	logic [DATA_W-1:0]    segoff;
	logic [PAGES_W-1:0]   pages;
	logic [PAGES_W-1:0]   pages_m1;

	assign segs     = d2_operand >> lg_q;
	assign segoff   = d2_operand & ((DATA_W'(1) << lg_q) - DATA_W'(1));
	assign pages    = segoff[PAGE_LOG2 +: PAGES_W];
	assign pages_m1 = pages - PAGES_W'(1);

	logic                  vld_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [DATA_W-1:0]     prod_lo_s1;
	logic [31:0]           prod_hi_s1;
	logic [PAGES_W+PP_W-1:0] pprod_s1;
	logic                  pnz_s1;
	logic [PAGE_LOG2-1:0]  off_s1;
	logic [DATA_W-1:0]     segq_s1;
	logic [USABLE_W-1:0]   segr_s1;
	logic [PAGES_W-1:0]    pq_s1;
	logic [PP_W-1:0]       pr_s1;

	logic [DATA_W-1:0]     hi_prod;

	assign hi_prod = DATA_W'(segs[63:32]) * DATA_W'(usable_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1     <= d2_cmd;
			prod_lo_s1 <= DATA_W'(segs[31:0]) * DATA_W'(usable_q);
			prod_hi_s1 <= hi_prod[31:0];
			pprod_s1   <= (PAGES_W + PP_W)'(pages_m1) * (PAGES_W + PP_W)'(PAGE_PAYLOAD);
			pnz_s1     <= pages != '0;
			off_s1     <= segoff[PAGE_LOG2-1:0];
			segq_s1    <= d2_segq;
			segr_s1    <= d2_segr;
			pq_s1      <= d2_q;
			pr_s1      <= d2_r;
		end
	end

	// final assembly of both directions
	logic [PAGE_LOG2-1:0] hdr;
	logic                 in_hdr;
	logic [DATA_W-1:0]    res_a;
	logic [DATA_W-1:0]    pos_off;
	logic [DATA_W-1:0]    res_p;
	logic                 end_form;
	logic [DATA_W-1:0]    conv;
	logic                 flag;

	always_comb begin
		hdr    = pnz_s1 ? PAGE_LOG2'(SHORT_HEADER_BYTES) : PAGE_LOG2'(LONG_HEADER_BYTES);
		in_hdr = (off_s1 != '0) && (off_s1 < hdr);
		res_a  = prod_lo_s1 + {prod_hi_s1, 32'd0}
			+ (pnz_s1 ? DATA_W'(FIRST_PAYLOAD) + DATA_W'(pprod_s1) : '0)
			+ ((off_s1 != '0 && !in_hdr) ? DATA_W'(off_s1 - hdr) : '0);

		end_form = cmd_s1 == CMD_POS_TO_END;
		if (segr_s1 < USABLE_W'(FIRST_PAYLOAD)) begin
			if (end_form && segr_s1 == '0) begin
				pos_off = '0;
			end else begin
				pos_off = DATA_W'(segr_s1) + DATA_W'(LONG_HEADER_BYTES);
			end
		end else begin
			pos_off = DATA_W'(PAGE_BYTES) + (DATA_W'(pq_s1) << PAGE_LOG2) + DATA_W'(pr_s1)
				+ ((end_form && pr_s1 == '0) ? '0 : DATA_W'(SHORT_HEADER_BYTES));
		end
		res_p = (segq_s1 << lg_q) + pos_off;

		unique case (cmd_s1)
			CMD_POS_TO_ADDR, CMD_POS_TO_END: begin
				conv = res_p;
				flag = 1'b0;
			end
			CMD_ADDR_TO_POS: begin
				conv = res_a;
				flag = in_hdr;
			end
			CMD_UNUSED: begin
				conv = '0;
				flag = 1'b0;
			end
			default: begin
				conv = '0;
				flag = 1'b0;
			end
		endcase
	end

	logic [DATA_W-1:0] conv_s2;
	logic              flag_s2;
	logic              vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			conv_s2 <= conv;
			flag_s2 <= flag;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {(OUT_TDATA_W - DATA_W - 1)'(0), flag_s2, conv_s2};

endmodule

FILE: sv/lpc_div.sv
// pipelined restoring divider, one quotient bit per stage
module lpc_div
	import lpc_pkg::*;
#(
	parameter int W  = 64,
	parameter int DW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [W-1:0]  quotient,
	output logic [DW-1:0] remainder,
	output logic [SW-1:0] out_side
);

	logic          vld_c  [0:W];
	logic [DW-1:0] rem_c  [0:W];
	logic [W-1:0]  nq_c   [0:W];
	logic [SW-1:0] side_c [0:W];

	assign vld_c[0]  = in_valid;
	assign rem_c[0]  = '0;
	assign nq_c[0]   = dividend;
	assign side_c[0] = in_side;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic          vld_s;
		logic [DW-1:0] rem_s;
		logic [W-1:0]  nq_s;
		logic [SW-1:0] side_s;
		logic [DW:0]   trial;
		logic [DW:0]   diff;
		logic          ge;

		// shift in the next dividend bit and try a subtract
		assign trial = {rem_c[k], nq_c[k][W-1]};
		assign diff  = trial - {1'b0, divisor};
		assign ge    = trial >= {1'b0, divisor};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (adv) begin
				vld_s <= vld_c[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				nq_s   <= {nq_c[k][W-2:0], ge};
				side_s <= side_c[k];
			end
		end

		assign vld_c[k+1]  = vld_s;
		assign rem_c[k+1]  = rem_s;
		assign nq_c[k+1]   = nq_s;
		assign side_c[k+1] = side_s;
	end

	assign out_valid = vld_c[W];
	assign quotient  = nq_c[W];
	assign remainder = rem_c[W];
	assign out_side  = side_c[W];

endmodule

FILE: tb/sv/log_position_converter_tb.sv
// self-checking testbench of the log position converter with random traffic and backpressure
module log_position_converter_tb;
	import lpc_pkg::*;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] operand;
	} conv_request_t;

	typedef struct packed {
		logic [DATA_W-1:0] converted;
		logic              inside_header;
	} conv_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // cmd, operand, zero padding
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // converted, inside_header, zero padding

	conv_request_t pending_items[$];
	conv_result_t  expected_results[$];
	logic [CFG_W-1:0] seg_log2_reg;
	int  mismatches;
	int  accepted_items;
	bit  item_taken;
	int  burst_left;
	int  gap_left;
	int  rx_cycle;
	int  rx_mode;
	int  holdoff_left;
	bit  holdoff_done;

	log_position_converter uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint unsigned clamped_log2(logic [CFG_W-1:0] reg_value);
		longint unsigned v;
		v = reg_value;
		if (v < SEG_LOG2_MIN) v = SEG_LOG2_MIN;
		if (v > SEG_LOG2_MAX) v = SEG_LOG2_MAX;
		return v;
	endfunction

	function automatic longint unsigned segment_usable(logic [CFG_W-1:0] reg_value);
		longint unsigned pages;
		pages = (64'd1 << clamped_log2(reg_value)) / PAGE_BYTES;
		return pages * PAGE_PAYLOAD + SHORT_HEADER_BYTES - LONG_HEADER_BYTES;
	endfunction

	function automatic conv_result_t predict_conversion(conv_request_t req,
			logic [CFG_W-1:0] reg_value);
		conv_result_t    res;
		longint unsigned lg, usable, segs, left, off, pages, rem, hdr, segoff;
		lg = clamped_log2(reg_value);
		usable = segment_usable(reg_value);
		res = '0;
		case (req.cmd)
			CMD_POS_TO_ADDR, CMD_POS_TO_END: begin
				segs = req.operand / usable;
				left = req.operand % usable;
				if (left < FIRST_PAYLOAD) begin
					if (req.cmd == CMD_POS_TO_END && left == 0)
						off = 0;
					else
						off = left + LONG_HEADER_BYTES;
				end else begin
					left -= FIRST_PAYLOAD;
					pages = left / PAGE_PAYLOAD;
					rem = left % PAGE_PAYLOAD;
					off = PAGE_BYTES + pages * PAGE_BYTES + rem;
					if (!(req.cmd == CMD_POS_TO_END && rem == 0))
						off += SHORT_HEADER_BYTES;
				end
				res.converted = (segs << lg) + off;
			end
			CMD_ADDR_TO_POS: begin
				segs = req.operand >> lg;
				segoff = req.operand & ((64'd1 << lg) - 1);
				pages = segoff / PAGE_BYTES;
				off = segoff % PAGE_BYTES;
				res.converted = segs * usable;
				if (pages == 0) begin
					hdr = LONG_HEADER_BYTES;
				end else begin
					hdr = SHORT_HEADER_BYTES;
					res.converted += FIRST_PAYLOAD + (pages - 1) * PAGE_PAYLOAD;
				end
				if (off > 0) begin
					if (off < hdr)
						res.inside_header = 1'b1;
					else
						res.converted += off - hdr;
				end
			end
			default: res = '0;
		endcase
		return res;
	endfunction

	task automatic add_item(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] operand);
		conv_request_t req;
		req.cmd = cmd;
		req.operand = operand;
		pending_items.push_back(req);
	endtask

	// operand biased towards page, header and segment edges
	function automatic logic [DATA_W-1:0] pick_operand(logic [CMD_W-1:0] cmd,
			logic [CFG_W-1:0] reg_value);
		longint unsigned lg, usable, segs, base;
		lg = clamped_log2(reg_value);
		usable = segment_usable(reg_value);
		segs = $urandom_range(0, 40);
		case ($urandom_range(0, 5))
			0: return {$urandom, $urandom};
			1: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 20000);
			2: begin
				if (cmd == CMD_ADDR_TO_POS)
					return (segs << lg) + $urandom_range(0, (1 << lg) - 1);
				return segs * usable + $urandom_range(0, usable - 1);
			end
			3: begin
				if (cmd == CMD_ADDR_TO_POS) begin
					base = (segs << lg)
						+ $urandom_range(0, (1 << (lg - PAGE_LOG2)) - 1) * PAGE_BYTES;
					return base + $urandom_range(0, 48);
				end
				base = segs * usable;
				if ($urandom_range(0, 3) == 0)
					return base + $urandom_range(0, 2) - 1;
				return base + FIRST_PAYLOAD
					+ $urandom_range(0, (1 << (lg - PAGE_LOG2)) - 2) * PAGE_PAYLOAD
					+ $urandom_range(0, 2) - 1;
			end
			4: return ({$urandom, $urandom} >> $urandom_range(0, 63));
			default: begin
				if (cmd == CMD_ADDR_TO_POS)
					return (segs << lg) - $urandom_range(0, 2);
				return usable * segs - $urandom_range(0, 2);
			end
		endcase
	endfunction

	task automatic add_random_items(int count);
		logic [CMD_W-1:0] cmd;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0)
				cmd = CMD_UNUSED;
			else
				cmd = CMD_W'($urandom_range(CMD_POS_TO_ADDR, CMD_ADDR_TO_POS));
			add_item(cmd, pick_operand(cmd, seg_log2_reg));
		end
	endtask

	task automatic add_directed_items();
		longint unsigned usable;
		usable = segment_usable(seg_log2_reg);
		add_item(CMD_POS_TO_ADDR, 64'd0);
		add_item(CMD_POS_TO_END, 64'd0);
		add_item(CMD_POS_TO_ADDR, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(CMD_POS_TO_END, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(CMD_POS_TO_ADDR, DATA_W'(FIRST_PAYLOAD));
		add_item(CMD_POS_TO_END, DATA_W'(FIRST_PAYLOAD));
		add_item(CMD_POS_TO_END, DATA_W'(FIRST_PAYLOAD + PAGE_PAYLOAD));
		add_item(CMD_POS_TO_ADDR, usable - 1);
		add_item(CMD_POS_TO_END, usable);
		add_item(CMD_POS_TO_END, DATA_W'(FIRST_PAYLOAD + 5));
		add_item(CMD_ADDR_TO_POS, 64'd0);
		add_item(CMD_ADDR_TO_POS, 64'd1);
		add_item(CMD_ADDR_TO_POS, DATA_W'(LONG_HEADER_BYTES - 1));
		add_item(CMD_ADDR_TO_POS, DATA_W'(LONG_HEADER_BYTES));
		add_item(CMD_ADDR_TO_POS, DATA_W'(PAGE_BYTES));
		add_item(CMD_ADDR_TO_POS, DATA_W'(PAGE_BYTES + SHORT_HEADER_BYTES - 1));
		add_item(CMD_ADDR_TO_POS, DATA_W'(PAGE_BYTES + SHORT_HEADER_BYTES));
		add_item(CMD_ADDR_TO_POS, (64'd1 << clamped_log2(seg_log2_reg)) - 1);
		add_item(CMD_ADDR_TO_POS, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(CMD_UNUSED, 64'd0);
	endtask

	task automatic write_segment_log2(logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		seg_log2_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic report_mismatch(string what, conv_result_t got, conv_result_t want);
		mismatches++;
		$display("%0t %s: got %h/%b expected %h/%b", $realtime, what,
			got.converted, got.inside_header, want.converted, want.inside_header);
	endtask

	// input driver: bursts with random gaps, valid held until the transfer
	always @(negedge clk) begin
		if (item_taken) begin
			void'(pending_items.pop_front());
			item_taken = 1'b0;
		end
		if (arst_n && !(s_tvalid && !item_taken && pending_items.size() > 0 && s_tdata ==
				{{(IN_TDATA_W-CMD_W-DATA_W){1'b0}}, pending_items[0].operand,
				pending_items[0].cmd} && s_tvalid)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {{(IN_TDATA_W-CMD_W-DATA_W){1'b0}}, pending_items[0].operand,
					pending_items[0].cmd};
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: changing stall pattern plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 3);
			if (!holdoff_done && accepted_items >= 400) begin
				holdoff_done = 1'b1;
				holdoff_left = 300;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ((rx_cycle / 8) % 2 == 0);
				endcase
			end
		end
	end

	// input side transfers become expectations, output side transfers are checked
	always @(posedge clk) begin
		conv_request_t req;
		conv_result_t  got;
		if (s_tvalid && s_tready) begin
			req.cmd = s_tdata[CMD_W-1:0];
			req.operand = s_tdata[CMD_W +: DATA_W];
			expected_results.push_back(predict_conversion(req, seg_log2_reg));
			accepted_items++;
			item_taken = 1'b1;
		end
		if (m_tvalid && m_tready) begin
			got.converted = m_tdata[DATA_W-1:0];
			got.inside_header = m_tdata[DATA_W];
			if (expected_results.size() == 0)
				report_mismatch("unexpected result", got, '0);
			else if (got != expected_results[0])
				report_mismatch("wrong result", got, expected_results.pop_front());
			else
				void'(expected_results.pop_front());
		end
	end

	initial begin
		logic [CFG_W-1:0] settings[6];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		accepted_items = 0;
		item_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		rx_cycle = 0;
		rx_mode = 0;
		holdoff_left = 0;
		holdoff_done = 1'b0;
		seg_log2_reg = CFG_W'(SEG_LOG2_RESET);
		settings = '{CFG_W'(SEG_LOG2_RESET), CFG_W'(SEG_LOG2_MIN), CFG_W'(SEG_LOG2_MAX),
			5'd0, 5'd31, CFG_W'($urandom_range(SEG_LOG2_MIN + 1, SEG_LOG2_MAX - 1))};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0)
				write_segment_log2(settings[phase]);
			if (phase == 0)
				add_directed_items();
			add_random_items(180);
			wait (pending_items.size() == 0 && expected_results.size() == 0);
			@(posedge clk);
		end
		repeat (120) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
